// File: rtl/core/med5_pkg.sv
// shared types, constants and compare helpers for the five-point median filter
// no dependencies
package med5_pkg;

    localparam int CHANNELS    = 8;
    localparam int RESET_PULSE = 1500;
    localparam int DEPTH       = 5;
    localparam int PULSE_W     = 16;
    localparam int CH_W        = 3;
    localparam int SLOT_W      = 3;
    localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef pulse_t [DEPTH-1:0] quint_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [CH_AW-1:0]   addr_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            fend;
        logic            in_range;
    } side_t;

    function automatic pulse_t pmin(input pulse_t a, input pulse_t b);
        return (a > b) ? b : a;
    endfunction

    function automatic pulse_t pmax(input pulse_t a, input pulse_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/core/med5_hist.sv
// history memory, one word per channel with a 16-bit lane per frame slot, plus per-entry valid bits
// depends on med5_pkg
module med5_hist (
    input  logic             clk,
    input  logic             rstn,
    input  logic             wr,
    input  logic             in_range,
    input  med5_pkg::addr_t  addr,
    input  med5_pkg::pulse_t pulse,
    input  med5_pkg::slot_t  cur,
    output med5_pkg::quint_t vals
);

    med5_pkg::quint_t           mem       [med5_pkg::CHANNELS];
    logic [med5_pkg::DEPTH-1:0] valid_reg [med5_pkg::CHANNELS];
    med5_pkg::quint_t           rd_reg;
    logic [med5_pkg::DEPTH-1:0] vld_rd_reg;
    med5_pkg::slot_t            cur_reg;
    med5_pkg::pulse_t           pulse_reg;

    // lane write into the current slot, whole word read
    always_ff @(posedge clk) begin
        if (wr && in_range) begin
            mem[addr][cur] <= pulse;
        end
        if (wr) begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int c = 0; c < med5_pkg::CHANNELS; c++) begin
                valid_reg[c] <= '0;
            end
        end else if (wr && in_range) begin
            valid_reg[addr][cur] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (wr) begin
            vld_rd_reg <= valid_reg[addr];
            cur_reg    <= cur;
            pulse_reg  <= pulse;
        end
    end

    // the entry written by this transfer is forwarded from the input
    always_comb begin
        for (int b = 0; b < med5_pkg::DEPTH; b++) begin
            if (cur_reg == med5_pkg::SLOT_W'(b)) begin
                vals[b] = pulse_reg;
            end else if (vld_rd_reg[b]) begin
                vals[b] = rd_reg[b];
            end else begin
                vals[b] = med5_pkg::PULSE_W'(med5_pkg::RESET_PULSE);
            end
        end
    end

endmodule

// File: rtl/core/med5_sort.sv
// pipelined seven compare-swap median-of-five network, three register stages
// depends on med5_pkg
module med5_sort (
    input  logic             clk,
    input  logic             en,
    input  med5_pkg::quint_t vals,
    output med5_pkg::pulse_t median
);

    med5_pkg::quint_t s1_reg;
    med5_pkg::quint_t s1_next;
    med5_pkg::quint_t s2_reg;
    med5_pkg::quint_t s2_next;
    med5_pkg::pulse_t med_reg;
    med5_pkg::pulse_t med_next;
    med5_pkg::quint_t t;
    med5_pkg::pulse_t a2;
    med5_pkg::pulse_t a3;

    // pairs (0,1) and (3,4)
    always_comb begin
        s1_next    = vals;
        s1_next[0] = med5_pkg::pmin(vals[0], vals[1]);
        s1_next[1] = med5_pkg::pmax(vals[0], vals[1]);
        s1_next[3] = med5_pkg::pmin(vals[3], vals[4]);
        s1_next[4] = med5_pkg::pmax(vals[3], vals[4]);
    end

    // pairs (0,3), (1,4), then (1,2)
    always_comb begin
        t          = s1_reg;
        t[0]       = med5_pkg::pmin(s1_reg[0], s1_reg[3]);
        t[3]       = med5_pkg::pmax(s1_reg[0], s1_reg[3]);
        t[1]       = med5_pkg::pmin(s1_reg[1], s1_reg[4]);
        t[4]       = med5_pkg::pmax(s1_reg[1], s1_reg[4]);
        s2_next    = t;
        s2_next[1] = med5_pkg::pmin(t[1], t[2]);
        s2_next[2] = med5_pkg::pmax(t[1], t[2]);
    end

    // pairs (2,3), then (1,2), keep the middle
    always_comb begin
        a2       = med5_pkg::pmin(s2_reg[2], s2_reg[3]);
        a3       = med5_pkg::pmax(s2_reg[1], a2);
        med_next = a3;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            med_reg <= med_next;
        end
    end

    assign median = med_reg;

endmodule

// File: rtl/core/multichannel_median5_filter_top.sv
// top level of the multichannel five-point median filter
// depends on med5_pkg, med5_hist and med5_sort
//
// usage: one channel sample per transfer on the s_ channel (s_channel,
// s_pulse_us, s_frame_end); one result per sample on the m_ channel
// (m_out_channel, m_median_us, m_out_frame_end), in the same order.
// each sample is written into the current frame slot of its channel and the
// result is the median of that channel's five stored samples. a sample with
// s_frame_end set advances the slot pointer, wrapping after five frames.
// throughput: one transfer per cycle while not stalled; the five slots of a
// channel are read as one memory word and the compare-swap network is pipelined.
// path: an input transfer loads the memory read register at the transfer edge,
// then passes the three network stages before m_valid rises.
// reset: aresetn low for one clock clears the slot pointer and the per-entry
// valid bits, so every history entry reads as the default pulse of 1500;
// no clearing pass is needed.
// stall: while m_valid is high and m_ready low the whole pipeline holds and
// s_ready is low.
module multichannel_median5_filter_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [med5_pkg::CH_W-1:0]   s_channel,
    input  logic [med5_pkg::PULSE_W-1:0] s_pulse_us,
    input  logic                        s_frame_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [med5_pkg::CH_W-1:0]   m_out_channel,
    output logic [med5_pkg::PULSE_W-1:0] m_median_us,
    output logic                        m_out_frame_end
);

    logic             en;
    logic             acc;
    logic             in_range;
    med5_pkg::slot_t  slot_reg;
    med5_pkg::slot_t  slot_next;
    med5_pkg::quint_t vals;
    med5_pkg::pulse_t median;
    med5_pkg::side_t  side_in;
    med5_pkg::side_t  side_reg [4];
    logic [3:0]       vld_reg;
    logic [3:0]       vld_next;

    assign en       = !vld_reg[3] || m_ready;
    assign s_ready  = en;
    assign acc      = s_valid && en;
    assign in_range = (32'(s_channel) < med5_pkg::CHANNELS);

    assign side_in = '{ch: s_channel, fend: s_frame_end, in_range: in_range};

    always_comb begin
        slot_next = slot_reg;
        if (acc && s_frame_end) begin
            slot_next = (slot_reg == med5_pkg::SLOT_W'(med5_pkg::DEPTH - 1))
                      ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    med5_hist u_hist (
        .clk      (aclk),
        .rstn     (aresetn),
        .wr       (acc),
        .in_range (in_range),
        .addr     (s_channel[med5_pkg::CH_AW-1:0]),
        .pulse    (s_pulse_us),
        .cur      (slot_reg),
        .vals     (vals)
    );

    med5_sort u_sort (
        .clk    (aclk),
        .en     (en),
        .vals   (vals),
        .median (median)
    );

    assign vld_next = {vld_reg[2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
        end
    end

    assign m_valid         = vld_reg[3];
    assign m_out_channel   = side_reg[3].ch;
    assign m_out_frame_end = side_reg[3].fend;
    assign m_median_us     = side_reg[3].in_range ? median : '0;

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= med5_pkg::SLOT_W'(med5_pkg::DEPTH - 1))
        else $error("slot pointer out of range");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && en |=> vld_reg[1])
        else $error("item lost between read and network stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(slot_reg))
        else $error("slot pointer moved without a transfer");

endmodule
